>>> hw/rtl/brd_pkg.sv
// Shared types and constants for the BMP RLE8/RLE4 span decoder.
// No dependencies; every other file imports this package.
package brd_pkg;

  localparam int unsigned MaxDim = 4096;

  localparam int unsigned DimW   = 13;  // width/height registers and column
  localparam int unsigned RowW   = 14;  // signed row position
  localparam int unsigned PosW   = 12;  // reported row / column
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DimW-1:0] MaxDimC = DimW'(MaxDim);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_RLE4_MODE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_COLOR,
    PH_ESCAPE,
    PH_ABS,
    PH_PAD,
    PH_DX,
    PH_DY
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SPAN,
    KIND_EOL,
    KIND_END
  } kind_e;

  // escape codes seen after a zero first byte
  localparam logic [ByteW-1:0] ESC_EOL   = 8'd0;
  localparam logic [ByteW-1:0] ESC_END   = 8'd1;
  localparam logic [ByteW-1:0] ESC_DELTA = 8'd2;

  typedef struct packed {
    logic            rle4_mode;
    logic [DimW-1:0] image_width;
    logic [DimW-1:0] image_height;
  } brd_cfg_t;

  typedef struct packed {
    phase_e                 phase;
    logic [DimW-1:0]        column;
    logic signed [RowW-1:0] row_pos;
    logic [ByteW-1:0]       held_count;
    logic [ByteW-1:0]       abs_remaining;
    logic                   abs_parity;
    logic                   done;
  } brd_state_t;

  typedef struct packed {
    kind_e            kind;
    logic [PosW-1:0]  row;
    logic [PosW-1:0]  start_column;
    logic [ByteW-1:0] span_length;
    logic [ByteW-1:0] even_index;
    logic [ByteW-1:0] odd_index;
  } brd_result_t;

endpackage

>>> hw/rtl/brd_in_if.sv
// Input channel: one compressed stream byte per request.
// Depends on brd_pkg.
interface brd_in_if import brd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             frame_start;

  modport source (output valid, data_byte, frame_start, input ready);
  modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

>>> hw/rtl/brd_out_if.sv
// Output channel: one span / line end / bitmap end record per request.
// Depends on brd_pkg.
interface brd_out_if import brd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [PosW-1:0]  row;
  logic [PosW-1:0]  start_column;
  logic [ByteW-1:0] span_length;
  logic [ByteW-1:0] even_index;
  logic [ByteW-1:0] odd_index;

  modport source (output valid, kind, row, start_column, span_length, even_index,
                  odd_index, input ready);
  modport sink   (input valid, kind, row, start_column, span_length, even_index,
                  odd_index, output ready);
endinterface

>>> hw/rtl/brd_step.sv
// Record state machine step: next decoder state and optional result for one byte.
// Purely combinational; depends on brd_pkg.
module brd_step import brd_pkg::*; (
  input  brd_cfg_t         cfg_i,
  input  brd_state_t       st_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             frame_start_i,
  output brd_state_t       st_o,
  output logic             res_valid_o,
  output brd_result_t      res_o
);

  logic [DimW-1:0]  eff_width;
  logic [DimW-1:0]  eff_height;
  brd_state_t       cur;
  logic [ByteW-1:0] want;
  logic [DimW-1:0]  avail;
  logic [DimW-1:0]  len;
  logic             span_ok;
  logic [ByteW-1:0] ev_idx;
  logic [ByteW-1:0] od_idx;
  logic [1:0]       take;
  logic [ByteW-1:0] rem_next;
  logic             stop;

  assign eff_width  = (cfg_i.image_width  > MaxDimC) ? MaxDimC : cfg_i.image_width;
  assign eff_height = (cfg_i.image_height > MaxDimC) ? MaxDimC : cfg_i.image_height;

  always_comb begin
    cur = st_i;
    if (frame_start_i) begin
      cur.phase         = PH_FIRST;
      cur.column        = '0;
      cur.row_pos       = $signed({1'b0, eff_height}) - RowW'(1);
      cur.held_count    = '0;
      cur.abs_remaining = '0;
      cur.abs_parity    = 1'b0;
      cur.done          = 1'b0;
    end
  end

  // literal bytes carry one (RLE8) or up to two (RLE4) pixels
  always_comb begin
    if (!cfg_i.rle4_mode) begin
      take = 2'd1;
    end else if (cur.abs_remaining >= 8'd2) begin
      take = 2'd2;
    end else begin
      take = cur.abs_remaining[1:0];
    end
  end
  assign rem_next = cur.abs_remaining - ByteW'(take);

  assign want = (cur.phase == PH_COLOR) ? cur.held_count : ByteW'(take);

  // span clipped at the width
  assign avail   = eff_width - cur.column;
  assign len     = (DimW'(want) < avail) ? DimW'(want) : avail;
  assign span_ok = (cur.column < eff_width) && (want != '0);
  assign ev_idx  = cfg_i.rle4_mode ? {4'd0, byte_i[7:4]} : byte_i;
  assign od_idx  = cfg_i.rle4_mode ? {4'd0, byte_i[3:0]} : byte_i;

  assign stop = cur.row_pos[RowW-1] || (cur.column > eff_width);

  always_comb begin
    st_o        = cur;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = KIND_SPAN;

    if (!cur.done) begin
      case (cur.phase)
        PH_FIRST: begin
          if (stop) begin
            st_o.done   = 1'b1;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_END;
          end else if (byte_i != '0) begin
            st_o.held_count = byte_i;
            st_o.phase      = PH_COLOR;
          end else begin
            st_o.phase = PH_ESCAPE;
          end
        end
        PH_COLOR: begin
          if (span_ok) begin
            res_valid_o        = 1'b1;
            res_o.row          = cur.row_pos[PosW-1:0];
            res_o.start_column = cur.column[PosW-1:0];
            res_o.span_length  = len[ByteW-1:0];
            res_o.even_index   = ev_idx;
            res_o.odd_index    = od_idx;
            st_o.column        = cur.column + len;
          end
          st_o.held_count = '0;
          st_o.phase      = PH_FIRST;
        end
        PH_ESCAPE: begin
          case (byte_i)
            ESC_EOL: begin
              res_valid_o  = 1'b1;
              res_o.kind   = KIND_EOL;
              res_o.row    = cur.row_pos[PosW-1:0];
              st_o.row_pos = cur.row_pos - RowW'(1);
              st_o.column  = '0;
              st_o.phase   = PH_FIRST;
            end
            ESC_END: begin
              res_valid_o = 1'b1;
              res_o.kind  = KIND_END;
              st_o.done   = 1'b1;
              st_o.phase  = PH_FIRST;
            end
            ESC_DELTA: begin
              st_o.phase = PH_DX;
            end
            default: begin
              st_o.abs_remaining = byte_i;
              st_o.abs_parity    = 1'b0;
              st_o.phase         = PH_ABS;
            end
          endcase
        end
        PH_ABS: begin
          if (span_ok) begin
            res_valid_o        = 1'b1;
            res_o.row          = cur.row_pos[PosW-1:0];
            res_o.start_column = cur.column[PosW-1:0];
            res_o.span_length  = len[ByteW-1:0];
            res_o.even_index   = ev_idx;
            res_o.odd_index    = od_idx;
            st_o.column        = cur.column + len;
          end
          st_o.abs_remaining = rem_next;
          st_o.abs_parity    = ~cur.abs_parity;
          // odd byte count: one pad byte keeps the record 16-bit aligned
          if (rem_next == '0) begin
            st_o.phase = (~cur.abs_parity) ? PH_PAD : PH_FIRST;
          end
        end
        PH_PAD: begin
          st_o.abs_parity = 1'b0;
          st_o.phase      = PH_FIRST;
        end
        PH_DX: begin
          st_o.held_count = byte_i;
          st_o.phase      = PH_DY;
        end
        PH_DY: begin
          st_o.column     = cur.column + DimW'(cur.held_count);
          st_o.row_pos    = cur.row_pos - $signed({{(RowW-ByteW){1'b0}}, byte_i});
          st_o.held_count = '0;
          st_o.phase      = PH_FIRST;
        end
        default: begin
          st_o.phase = PH_FIRST;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/bmp_rle_span_decoder_core.sv
// BMP RLE8/RLE4 span decoder top level: input register, record state, result register.
// A byte is held in the input register, then its result in the result register, which must be free or being taken.
// Throughput: one byte per cycle while the result register is free or taken; the record state updates once per byte.
// Reset: mode, width and height clear to 0, record state to the start of a record at
// column 0 and row -1; a frame_start byte reloads the row from the height.
// Depends on brd_pkg, brd_in_if, brd_out_if and brd_step.
module bmp_rle_span_decoder_core import brd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DimW-1:0]    cfg_data_i,
  brd_in_if.sink             in_i,
  brd_out_if.source          out_o
);

  brd_cfg_t    cfg_q;
  brd_state_t  state_q, state_d;
  logic        in_valid_q;
  logic [ByteW-1:0] byte_q;
  logic        fs_q;
  logic        out_valid_q;
  brd_result_t res_q, res_d;
  logic        res_valid_d;
  logic        step_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RLE4_MODE:    cfg_q.rle4_mode    <= cfg_data_i[0];
        CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign step_go    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.data_byte;
      fs_q   <= in_i.frame_start;
    end
  end

  brd_step u_step (
    .cfg_i         (cfg_q),
    .st_i          (state_q),
    .byte_i        (byte_q),
    .frame_start_i (fs_q),
    .st_o          (state_d),
    .res_valid_o   (res_valid_d),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= PH_FIRST;
      state_q.column        <= '0;
      state_q.row_pos       <= '1;  // height 0 after reset, so row is -1
      state_q.held_count    <= '0;
      state_q.abs_remaining <= '0;
      state_q.abs_parity    <= 1'b0;
      state_q.done          <= 1'b0;
    end else if (step_go) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_go) begin
      out_valid_q <= res_valid_d;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = res_q.kind;
  assign out_o.row          = res_q.row;
  assign out_o.start_column = res_q.start_column;
  assign out_o.span_length  = res_q.span_length;
  assign out_o.even_index   = res_q.even_index;
  assign out_o.odd_index    = res_q.odd_index;

endmodule
